/* hw/rtl/dsa_pkg.sv */
// ----------------------------------------------------------------------------
// dsa_pkg
// types and constants shared by the slot allocator modules
// ----------------------------------------------------------------------------
`default_nettype none

package dsa_pkg;

    localparam int SLOT_W = 7;
    localparam int CNT_W  = 8;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [SLOT_W-1:0] slot_index;
        logic              search_down;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic              found_free;
        logic [SLOT_W-1:0] slot_count;
    } out_item_t;

    typedef struct packed {
        logic              set_one;
        logic              clr_one;
        logic              clr_all;
        logic [SLOT_W-1:0] addr;
    } map_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } seq_state_t;

endpackage

`default_nettype wire

/* hw/rtl/directional_slot_allocator.sv */
// ----------------------------------------------------------------------------
// directional_slot_allocator
// first-fit slot allocator with upward or downward scan and high-water count
// ----------------------------------------------------------------------------
//  channel   ports                          carries
//  input     s_valid, s_ready, s_item       req_type, slot_index, search_down
//  result    m_valid, m_ready, m_item       granted_slot, found_free, slot_count
//
//  allocate: accept, then scan (one used bit per cycle through the single map
//  read port), then commit
//  free, clear and unknown requests: accept, then commit
//  aresetn is synchronous active low and clears the map and the count at once
//  a result waits in the output register; the next item is accepted and
//  scanned meanwhile, and its commit waits until the output register is free
// ----------------------------------------------------------------------------
`default_nettype none

module directional_slot_allocator #(
    parameter int SLOTS = 80
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire dsa_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output dsa_pkg::out_item_t      m_item
);
    import dsa_pkg::*;

    logic [SLOT_W-1:0] rd_addr;
    logic              rd_bit;
    map_cmd_t          cmd;

    dsa_seq #(
        .SLOTS(SLOTS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .rd_addr (rd_addr),
        .rd_bit  (rd_bit),
        .cmd     (cmd)
    );

    dsa_map #(
        .SLOTS(SLOTS)
    ) u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .rd_bit  (rd_bit),
        .cmd     (cmd)
    );

endmodule

`default_nettype wire

/* hw/rtl/dsa_map.sv */
// ----------------------------------------------------------------------------
// dsa_map
// used-bit map, one bit per slot, single read port and update port
// ----------------------------------------------------------------------------
`default_nettype none

module dsa_map #(
    parameter int SLOTS = 80
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [dsa_pkg::SLOT_W-1:0] rd_addr,
    output logic                           rd_bit,
    input  wire dsa_pkg::map_cmd_t         cmd
);
    import dsa_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0] used_reg;
    logic [SLOTS-1:0] used_next;

    always_comb begin
        used_next = used_reg;
        if (cmd.clr_all) begin
            used_next = '0;
        end else if (cmd.set_one) begin
            used_next[cmd.addr[IDX_W-1:0]] = 1'b1;
        end else if (cmd.clr_one) begin
            used_next[cmd.addr[IDX_W-1:0]] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else begin
            used_reg <= used_next;
        end
    end

    assign rd_bit = used_reg[rd_addr[IDX_W-1:0]];

endmodule

`default_nettype wire

/* hw/rtl/dsa_seq.sv */
// ----------------------------------------------------------------------------
// dsa_seq
// request sequencer: scan pointer, high-water count and result register
// ----------------------------------------------------------------------------
`default_nettype none

module dsa_seq #(
    parameter int SLOTS = 80
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire dsa_pkg::in_item_t          s_item,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output dsa_pkg::out_item_t              m_item,
    output logic [dsa_pkg::SLOT_W-1:0]      rd_addr,
    input  wire logic                       rd_bit,
    output dsa_pkg::map_cmd_t               cmd
);
    import dsa_pkg::*;

    localparam logic [CNT_W-1:0]  SLOT_CNT = CNT_W'(SLOTS);
    localparam logic [SLOT_W-1:0] LAST     = SLOT_W'(SLOTS - 1);

    seq_state_t        state_reg, state_next;
    logic [1:0]        req_reg, req_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              down_reg, down_next;
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  hw_reg, hw_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         out_reg, out_next;

    logic              accept;
    logic              at_end;
    logic              scan_stop;
    logic              commit_go;
    logic [SLOT_W-1:0] start_slot;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign at_end     = down_reg ? (ptr_reg == '0) : (ptr_reg == LAST);
    assign scan_stop  = !rd_bit || at_end;
    assign commit_go  = (state_reg == ST_COMMIT) && (!m_valid_reg || m_ready);
    assign start_slot = ({1'b0, s_item.slot_index} >= SLOT_CNT) ? LAST : s_item.slot_index;
    assign rd_addr    = ptr_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_item.req_type == REQ_ALLOC) ? ST_SCAN : ST_COMMIT;
                end
            end
            ST_SCAN: begin
                if (scan_stop) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (commit_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        req_next     = req_reg;
        idx_next     = idx_reg;
        down_next    = down_reg;
        ptr_next     = ptr_reg;
        found_next   = found_reg;
        hw_next      = hw_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.addr     = ptr_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next   = s_item.req_type;
                    idx_next   = s_item.slot_index;
                    down_next  = s_item.search_down;
                    ptr_next   = start_slot;
                    found_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (scan_stop) begin
                    found_next = !rd_bit;
                end else if (down_reg) begin
                    ptr_next = ptr_reg - 1'b1;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_COMMIT: begin
                if (commit_go) begin
                    out_next.granted_slot = '0;
                    out_next.found_free   = 1'b0;
                    unique case (req_reg)
                        REQ_ALLOC: begin
                            cmd.set_one           = 1'b1;
                            out_next.granted_slot = ptr_reg;
                            out_next.found_free   = found_reg;
                            if ({1'b0, ptr_reg} >= hw_reg) begin
                                hw_next = {1'b0, ptr_reg} + 1'b1;
                            end
                        end
                        REQ_FREE: begin
                            cmd.addr = idx_reg;
                            if (({1'b0, idx_reg} < hw_reg) && ({1'b0, idx_reg} < SLOT_CNT)) begin
                                cmd.clr_one = 1'b1;
                                if ({1'b0, idx_reg} + 1'b1 == hw_reg) begin
                                    hw_next = hw_reg - 1'b1;
                                end
                            end
                        end
                        REQ_CLEAR: begin
                            cmd.clr_all = 1'b1;
                            hw_next     = '0;
                        end
                        default: begin
                        end
                    endcase
                    out_next.slot_count = hw_next[SLOT_W-1:0];
                    m_valid_next        = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            hw_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hw_reg      <= hw_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        down_reg  <= down_next;
        ptr_reg   <= ptr_next;
        found_reg <= found_next;
        out_reg   <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule

`default_nettype wire

/* hw/rtl/dsa_checker.sv */
// ----------------------------------------------------------------------------
// dsa_checker
// port-level checks for the slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

module dsa_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire dsa_pkg::in_item_t  s_item,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire dsa_pkg::out_item_t m_item
);
    import dsa_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // every item is busy in the cycle after its acceptance
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after accept");

    // a new result is only produced while the block is busy
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without a pending item");

    // a granted free slot lies below the count (count of full width wraps to zero)
    a_grant_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.found_free |->
            (m_item.granted_slot < m_item.slot_count) || (m_item.slot_count == '0))
        else $error("granted slot not below count");

endmodule

bind directional_slot_allocator dsa_checker u_dsa_checker (.*);

`default_nettype wire

/* verif/slot_ledger_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_ledger_pkg
// tracks the used-bit map and high-water count of the slot allocator, works
// out the grant for every accepted request and checks returned grants in order
// ----------------------------------------------------------------------------
package slot_ledger_pkg;

    import dsa_pkg::*;

    localparam int NUM_SLOTS = 80;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    class slot_grant_ledger;

        bit          slot_used [NUM_SLOTS];
        int unsigned high_water;
        out_item_t   awaited_grants [$];
        int unsigned mismatches;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            high_water = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return awaited_grants.size();
        endfunction

        // updates the map and queues the grant this request must produce
        function void note_request(in_item_t req);
            out_item_t   grant;
            int          start;
            int          pick;
            bit          hit;
            int unsigned idx;
            grant = '0;
            idx = 32'(req.slot_index);
            case (req.req_type)
                REQ_ALLOC: begin
                    start = (idx >= NUM_SLOTS) ? NUM_SLOTS - 1 : idx;
                    hit = 1'b0;
                    pick = req.search_down ? 0 : NUM_SLOTS - 1;
                    if (req.search_down) begin
                        for (int s = start; s >= 0 && !hit; s--) begin
                            if (!slot_used[s]) begin
                                pick = s;
                                hit = 1'b1;
                            end
                        end
                    end else begin
                        for (int s = start; s < NUM_SLOTS && !hit; s++) begin
                            if (!slot_used[s]) begin
                                pick = s;
                                hit = 1'b1;
                            end
                        end
                    end
                    slot_used[pick] = 1'b1;
                    if (pick >= high_water) high_water = pick + 1;
                    grant.granted_slot = pick[SLOT_W-1:0];
                    grant.found_free = hit;
                end
                REQ_FREE: begin
                    if (idx < high_water && idx < NUM_SLOTS) begin
                        if (idx + 1 == high_water) high_water--;
                        slot_used[idx] = 1'b0;
                    end
                end
                REQ_CLEAR: begin
                    foreach (slot_used[i]) slot_used[i] = 1'b0;
                    high_water = 0;
                end
                default: begin
                end
            endcase
            grant.slot_count = high_water[SLOT_W-1:0];
            awaited_grants.push_back(grant);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (awaited_grants.size() == 0) begin
                $error("unexpected item: granted_slot %0d found_free %0d slot_count %0d",
                       got.granted_slot, got.found_free, got.slot_count);
                mismatches++;
                return;
            end
            want = awaited_grants.pop_front();
            if (got.granted_slot !== want.granted_slot) begin
                $error("granted_slot: expected %0d, actual %0d",
                       want.granted_slot, got.granted_slot);
                mismatches++;
            end
            if (got.found_free !== want.found_free) begin
                $error("found_free: expected %0d, actual %0d",
                       want.found_free, got.found_free);
                mismatches++;
            end
            if (got.slot_count !== want.slot_count) begin
                $error("slot_count: expected %0d, actual %0d",
                       want.slot_count, got.slot_count);
                mismatches++;
            end
        endfunction

    endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// directed and random allocate, free, clear and unknown traffic into the slot
// allocator with random stalls on both channels; every grant is checked
// against a ledger of the slot map kept alongside the block
// ----------------------------------------------------------------------------
module tb_top;

    import dsa_pkg::*;
    import slot_ledger_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int CALM_FROM    = 1100;
    localparam int HOLD_CYCLES  = 500;
    localparam int HANG_LIMIT   = 4000;
    localparam int SETTLE       = NUM_SLOTS + 40;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    bit calm;
    bit hold_off;
    int unsigned idle_cycles;

    slot_grant_ledger ledger;

    directional_slot_allocator #(
        .SLOTS(NUM_SLOTS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic in_item_t make_req(logic [1:0] kind, int unsigned idx,
                                          int unsigned down);
        in_item_t req;
        req.req_type    = kind;
        req.slot_index  = idx[SLOT_W-1:0];
        req.search_down = down[0];
        return req;
    endfunction

    task automatic send_request(input in_item_t req);
        @(negedge aclk);
        s_valid = 1'b1;
        s_item  = req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ledger.note_request(req);
    endtask

    task automatic sender_gap();
        int unsigned n;
        n = $urandom_range(1, 15);
        @(negedge aclk);
        s_valid = 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (ledger.pending() != 0) @(posedge aclk);
    endtask

    function automatic in_item_t random_req(int unsigned alloc_pct);
        int unsigned r;
        int unsigned sub;
        int unsigned idx;
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
            idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, NUM_SLOTS - 1);
            return make_req(REQ_ALLOC, idx, $urandom_range(0, 1));
        end
        sub = $urandom_range(0, 19);
        if (sub == 0) return make_req(REQ_UNKNOWN, $urandom_range(0, 127), $urandom_range(0, 1));
        if (sub == 1) return make_req(REQ_CLEAR, $urandom_range(0, 127), $urandom_range(0, 1));
        if (sub <= 4 || ledger.high_water == 0)
            return make_req(REQ_FREE, $urandom_range(0, 127), $urandom_range(0, 1));
        // one time in three release the top slot, or else any slot below the high-water count
        if ($urandom_range(0, 2) == 0) idx = ledger.high_water - 1;
        else idx = $urandom_range(0, ledger.high_water - 1);
        return make_req(REQ_FREE, idx, $urandom_range(0, 1));
    endfunction

    // receiver side
    initial begin
        int unsigned n;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                @(negedge aclk);
                m_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_off = 1'b0;
            end else if (calm) begin
                @(negedge aclk);
                m_ready = 1'b1;
            end else begin
                n = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 120 : 20);
                @(negedge aclk);
                m_ready = 1'b1;
                repeat (n - 1) @(negedge aclk);
                n = $urandom_range(1, 15);
                @(negedge aclk);
                m_ready = 1'b0;
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    // result monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) ledger.check_result(m_item);
            if ((m_valid && m_ready) || (s_valid && s_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int unsigned sent;
        int unsigned episode_len;
        int unsigned alloc_pct;
        bit          held;
        bit          drained;
        in_item_t    req;
        ledger      = new();
        calm        = 1'b0;
        hold_off    = 1'b0;
        idle_cycles = 0;
        held        = 1'b0;
        drained     = 1'b0;
        s_valid     = 1'b0;
        s_item      = '0;
        aresetn     = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed
        send_request(make_req(REQ_CLEAR, 0, 0));
        send_request(make_req(REQ_ALLOC, 0, 0));
        send_request(make_req(REQ_ALLOC, 0, 0));
        send_request(make_req(REQ_ALLOC, 127, 0));
        send_request(make_req(REQ_ALLOC, 127, 1));
        send_request(make_req(REQ_ALLOC, NUM_SLOTS, 1));
        send_request(make_req(REQ_ALLOC, NUM_SLOTS - 1, 0));
        send_request(make_req(REQ_ALLOC, 0, 1));
        send_request(make_req(REQ_FREE, NUM_SLOTS - 1, 0));
        send_request(make_req(REQ_FREE, NUM_SLOTS - 1, 1));
        send_request(make_req(REQ_FREE, 127, 0));
        send_request(make_req(REQ_FREE, 1, 0));
        send_request(make_req(REQ_UNKNOWN, 127, 1));
        send_request(make_req(REQ_ALLOC, 64, 0));
        send_request(make_req(REQ_FREE, 0, 0));
        send_request(make_req(REQ_CLEAR, 127, 1));
        send_request(make_req(REQ_FREE, 0, 1));
        send_request(make_req(REQ_ALLOC, 42, 1));
        send_request(make_req(REQ_FREE, 42, 0));
        send_request(make_req(REQ_UNKNOWN, 0, 0));
        // fill the whole map, then scan both ways with no free slot
        for (int i = 0; i < NUM_SLOTS; i++) send_request(make_req(REQ_ALLOC, 0, 0));
        send_request(make_req(REQ_ALLOC, 0, 0));
        send_request(make_req(REQ_ALLOC, 127, 1));
        send_request(make_req(REQ_FREE, 0, 0));
        send_request(make_req(REQ_ALLOC, 127, 1));

        // random episodes
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                send_request(make_req(REQ_CLEAR, $urandom_range(0, 127), $urandom_range(0, 1)));
                sent++;
            end
            alloc_pct   = $urandom_range(40, 97);
            episode_len = $urandom_range(20, 160);
            for (int k = 0; k < episode_len && sent < RANDOM_ITEMS; k++) begin
                if (!calm && sent >= CALM_FROM) calm = 1'b1;
                if (!held && sent >= 300) begin
                    held = 1'b1;
                    hold_off = 1'b1;
                end
                if (!drained && sent >= 700) begin
                    drained = 1'b1;
                    @(negedge aclk);
                    s_valid = 1'b0;
                    wait_drained();
                end
                if (!calm && $urandom_range(0, 3) == 0) sender_gap();
                req = random_req(alloc_pct);
                send_request(req);
                if (req.req_type != REQ_UNKNOWN) sent++;
            end
        end
        @(negedge aclk);
        s_valid = 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
